### rtl/ssr_pkg.sv
package ssr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN   = 3'd4;

  localparam int unsigned NEEDLE_LEN_W  = 4;
  localparam int unsigned REPLACE_LEN_W = 5;
  localparam int unsigned REPLACE_BYTES = 16;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } win_ctrl_t;

endpackage

### rtl/ssr_stream_if.sv
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

### rtl/ssr_window.sv
module ssr_window #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssr_pkg::win_ctrl_t           ctrl,
  input  logic [7:0]                   push_byte,
  input  logic [8*DEPTH-1:0]           needle,
  input  logic [$clog2(DEPTH+1)-1:0]   len,
  output logic [7:0]                   oldest,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic                         match
);

  localparam int unsigned FW  = $clog2(DEPTH + 1);
  localparam int unsigned WIW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    win_r [DEPTH];
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [DEPTH-1:0] byte_ok;

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (ctrl.push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (ctrl.pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      win_r[fill_r[WIW-1:0]] <= push_byte;
    end else if (ctrl.pop) begin
      for (int i = 0; i < int'(DEPTH) - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      byte_ok[i] = (FW'(i) >= len) || (win_r[i] == needle[8*i +: 8]);
    end
  end

  assign match  = &byte_ok;
  assign oldest = win_r[0];
  assign fill   = fill_r;

endmodule

### rtl/stream_substring_replace.sv
// Streaming find-and-replace over a byte stream.
// Input transactions on in_ch carry one byte and an end flag. Result
// transactions on out_ch carry one byte, a flag saying whether the byte is
// valid, and an end flag on the final result of each text.
// Registers must be written by the user via cfg_we, cfg_index and cfg_wdata
// only while the block is idle (the block does not enforce this), and take
// effect from the next input transaction. Each accepted byte enters a window
// of up to MAX_NEEDLE bytes. A window of needle length equal to the needle is
// replaced; else the oldest bytes pass on until one less than the needle
// length remain, none at a text's end. Input is accepted in ST_IDLE, checked
// in ST_EVAL, and results leave from ST_POP, ST_REPL or ST_END. The sequencer
// emits at most one result per cycle through a single output register, while
// that register is free. in_ch is ready only while the sequencer idles. When
// the receiver stalls, the output register holds its result and the sequencer
// waits. Reset empties the window and clears the config and sequencer state.
module stream_substring_replace #(
  parameter int unsigned MAX_NEEDLE  = 8,
  parameter int unsigned MAX_REPLACE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssr_in_if.sink                          in_ch,
  ssr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned FW  = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned RLW = $clog2(MAX_REPLACE + 1);
  localparam int unsigned RIW = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_POP  = 5'b00100,
    ST_REPL = 5'b01000,
    ST_END  = 5'b10000
  } state_t;

  logic [63:0]                         needle_bytes_r;
  logic [ssr_pkg::NEEDLE_LEN_W-1:0]    needle_length_r;
  logic [63:0]                         replace_low_r;
  logic [63:0]                         replace_high_r;
  logic [ssr_pkg::REPLACE_LEN_W-1:0]   replace_length_r;

  state_t         state_r, state_nxt;
  logic           last_r, last_nxt;
  logic [FW-1:0]  target_r, target_nxt;
  logic [RLW-1:0] idx_r, idx_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       has_byte_r;
  logic       out_last_r;

  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_has;
  logic       emit_last;
  logic       slot_free;
  logic       in_accept;

  logic [FW-1:0]  len_eff;
  logic [FW-1:0]  keep;
  logic [RLW-1:0] rep_eff;
  logic [7:0]     rep_bytes [MAX_REPLACE];
  logic [127:0]   rep_word;

  ssr_pkg::win_ctrl_t win_ctrl;
  logic [7:0]         win_oldest;
  logic [FW-1:0]      win_fill;
  logic               win_match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_bytes_r   <= '0;
      needle_length_r  <= '0;
      replace_low_r    <= '0;
      replace_high_r   <= '0;
      replace_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::CFG_NEEDLE_BYTES:  needle_bytes_r   <= cfg_wdata;
        ssr_pkg::CFG_NEEDLE_LENGTH: needle_length_r  <= cfg_wdata[ssr_pkg::NEEDLE_LEN_W-1:0];
        ssr_pkg::CFG_REPLACE_LOW:   replace_low_r    <= cfg_wdata;
        ssr_pkg::CFG_REPLACE_HIGH:  replace_high_r   <= cfg_wdata;
        ssr_pkg::CFG_REPLACE_LEN:   replace_length_r <= cfg_wdata[ssr_pkg::REPLACE_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign len_eff = (needle_length_r > ssr_pkg::NEEDLE_LEN_W'(MAX_NEEDLE)) ?
                   FW'(MAX_NEEDLE) : needle_length_r[FW-1:0];
  assign rep_eff = (replace_length_r > ssr_pkg::REPLACE_LEN_W'(MAX_REPLACE)) ?
                   RLW'(MAX_REPLACE) : replace_length_r[RLW-1:0];
  assign keep    = (len_eff != '0) ? len_eff - FW'(1) : '0;

  assign rep_word = {replace_high_r, replace_low_r};
  always_comb begin
    for (int i = 0; i < int'(MAX_REPLACE); i++) begin
      rep_bytes[i] = rep_word[8*i +: 8];
    end
  end

  ssr_window #(
    .DEPTH(MAX_NEEDLE)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (win_ctrl),
    .push_byte(in_ch.in_byte),
    .needle   (needle_bytes_r[8*MAX_NEEDLE-1:0]),
    .len      (len_eff),
    .oldest   (win_oldest),
    .fill     (win_fill),
    .match    (win_match)
  );

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    target_nxt = target_r;
    idx_nxt    = idx_r;
    win_ctrl   = '0;
    emit       = 1'b0;
    emit_byte  = '0;
    emit_has   = 1'b1;
    emit_last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          win_ctrl.push = 1'b1;
          last_nxt      = in_ch.in_last;
          state_nxt     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((win_fill == len_eff) && (len_eff != '0) && win_match) begin
          win_ctrl.clear = 1'b1;
          idx_nxt        = '0;
          if (rep_eff != '0) begin
            state_nxt = ST_REPL;
          end else if (last_r) begin
            state_nxt = ST_END;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          target_nxt = last_r ? '0 : keep;
          state_nxt  = (win_fill > target_nxt) ? ST_POP : ST_IDLE;
        end
      end
      ST_POP: begin
        if (slot_free) begin
          emit         = 1'b1;
          emit_byte    = win_oldest;
          emit_last    = last_r && (win_fill == FW'(1));
          win_ctrl.pop = 1'b1;
          if ((win_fill - FW'(1)) == target_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REPL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rep_bytes[idx_r[RIW-1:0]];
          emit_last = last_r && ((idx_r + RLW'(1)) == rep_eff);
          idx_nxt   = idx_r + RLW'(1);
          if ((idx_r + RLW'(1)) == rep_eff) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_has  = 1'b0;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      target_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      target_r <= target_nxt;
      idx_r    <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      has_byte_r <= emit_has;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.has_byte = has_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule
